### rtl/core/ddmtc_pkg.sv
package ddmtc_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_TURN = 2'd2;

  localparam logic [2:0] REG_THRESHOLD_0 = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_1 = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_2 = 3'd2;
  localparam logic [2:0] REG_THRESHOLD_3 = 3'd3;
  localparam logic [2:0] REG_SPEED_0     = 3'd4;
  localparam logic [2:0] REG_SPEED_1     = 3'd5;
  localparam logic [2:0] REG_SPEED_2     = 3'd6;
  localparam logic [2:0] REG_SPEED_3     = 3'd7;

  localparam int DEG_HALF  = 180;
  localparam int DEG_FULL  = 360;
  localparam int CORR_GAIN = 20;

  localparam logic [7:0] DUTY_MAX = 8'd255;

  localparam int DIFF_W      = 17;
  localparam int SQ_W        = 32;
  localparam int RAD_W       = 33;
  localparam int ROOT_W      = 17;
  localparam int MREM_W      = 19;
  localparam int TURN_GOAL_W = 17;
  localparam int ITER_W      = 5;
  localparam logic [ITER_W-1:0] ITER_TOP = 5'd16;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_START = 4'd1;
  localparam logic [PC_W-1:0] PC_DIFF  = 4'd2;
  localparam logic [PC_W-1:0] PC_SQX   = 4'd3;
  localparam logic [PC_W-1:0] PC_SQY   = 4'd4;
  localparam logic [PC_W-1:0] PC_SUM   = 4'd5;
  localparam logic [PC_W-1:0] PC_ROOT  = 4'd6;
  localparam logic [PC_W-1:0] PC_MEVAL = 4'd7;
  localparam logic [PC_W-1:0] PC_MSEL  = 4'd8;
  localparam logic [PC_W-1:0] PC_MEMIT = 4'd9;
  localparam logic [PC_W-1:0] PC_TEVAL = 4'd10;
  localparam logic [PC_W-1:0] PC_TSEL  = 4'd11;
  localparam logic [PC_W-1:0] PC_TEMIT = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_START,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SUM,
    OP_ROOT,
    OP_MEVAL,
    OP_MSEL,
    OP_MEMIT,
    OP_TEVAL,
    OP_TSEL,
    OP_TEMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_WAIT_IN,
    JC_WAIT_OUT,
    JC_IF_NOT_TICK,
    JC_IF_MOVE_OFF,
    JC_IF_TURN_OFF,
    JC_LOOP
  } jump_t;

  typedef struct packed {
    op_t             op;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic is_tick;
    logic move_on;
    logic turn_on;
    logic iter_zero;
  } seq_flags_t;

  typedef struct packed {
    op_t  op;
    logic exec;
    logic idle;
  } seq_ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_IDLE:  w = '{op: OP_LATCH, jump: JC_WAIT_IN,     target: PC_START};
      PC_START: w = '{op: OP_START, jump: JC_IF_NOT_TICK, target: PC_IDLE};
      PC_DIFF:  w = '{op: OP_DIFF,  jump: JC_IF_MOVE_OFF, target: PC_TEVAL};
      PC_SQX:   w = '{op: OP_SQX,   jump: JC_NEXT,        target: PC_IDLE};
      PC_SQY:   w = '{op: OP_SQY,   jump: JC_NEXT,        target: PC_IDLE};
      PC_SUM:   w = '{op: OP_SUM,   jump: JC_NEXT,        target: PC_IDLE};
      PC_ROOT:  w = '{op: OP_ROOT,  jump: JC_LOOP,        target: PC_ROOT};
      PC_MEVAL: w = '{op: OP_MEVAL, jump: JC_NEXT,        target: PC_IDLE};
      PC_MSEL:  w = '{op: OP_MSEL,  jump: JC_NEXT,        target: PC_IDLE};
      PC_MEMIT: w = '{op: OP_MEMIT, jump: JC_WAIT_OUT,    target: PC_TEVAL};
      PC_TEVAL: w = '{op: OP_TEVAL, jump: JC_IF_TURN_OFF, target: PC_IDLE};
      PC_TSEL:  w = '{op: OP_TSEL,  jump: JC_NEXT,        target: PC_IDLE};
      PC_TEMIT: w = '{op: OP_TEMIT, jump: JC_WAIT_OUT,    target: PC_IDLE};
      default:  w = '{op: OP_NOP,   jump: JC_GOTO,        target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/ddmtc_sequencer.sv
module ddmtc_sequencer
  import ddmtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  seq_flags_t flags,
  output seq_ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;

  assign word = ucode_rom(pc);

  always_comb begin
    case (word.jump)
      JC_NEXT:        pc_next = pc + 1'b1;
      JC_GOTO:        pc_next = word.target;
      JC_WAIT_IN:     pc_next = flags.in_fire ? word.target : pc;
      JC_WAIT_OUT:    pc_next = flags.out_free ? word.target : pc;
      JC_IF_NOT_TICK: pc_next = flags.is_tick ? pc + 1'b1 : word.target;
      JC_IF_MOVE_OFF: pc_next = flags.move_on ? pc + 1'b1 : word.target;
      JC_IF_TURN_OFF: pc_next = flags.turn_on ? pc + 1'b1 : word.target;
      JC_LOOP:        pc_next = flags.iter_zero ? pc + 1'b1 : word.target;
      default:        pc_next = PC_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op   = word.op;
    ctrl.idle = (pc == PC_IDLE);
    case (word.jump)
      JC_WAIT_IN:  ctrl.exec = flags.in_fire;
      JC_WAIT_OUT: ctrl.exec = flags.out_free;
      default:     ctrl.exec = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef ASSERT_OFF
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_TEMIT)
    else $error("Sequencer left the program.");
`endif

endmodule

### rtl/core/diff_drive_move_turn_controller.sv
// A tick with a move active delivers its move result and then, if a turn is also active, a turn
// result; a tick with only a turn active delivers just the turn result. The move path is longest,
// as it repeats the square-root step until its iteration counter reaches zero. Start commands
// return to idle with no output. A stalled output holds the sequencer at its emit step.
// Synchronous reset idles the sequencer, ends any motion, empties the output register and
// loads the default thresholds and speeds.
module diff_drive_move_turn_controller
  import ddmtc_pkg::*;
#(
  parameter int NUM_STEPS         = 4,
  parameter int HEADING_FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic signed [15:0] position_x,
  input  logic signed [15:0] position_y,
  input  logic [12:0] heading,
  input  logic signed [15:0] target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        left_ccw,
  output logic [7:0]  left_duty,
  output logic        right_cw,
  output logic [7:0]  right_duty,
  output logic        from_turn,
  output logic        finished,
  output logic        last_of_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int HW     = 15 + HEADING_FRAC_BITS;
  localparam int CORR_W = HW + 5;
  localparam int MAG_W  = CORR_W + 1;
  localparam int TW     = 19 + HEADING_FRAC_BITS;
  localparam logic signed [HW-1:0] HALF   = HW'(DEG_HALF << HEADING_FRAC_BITS);
  localparam logic signed [HW-1:0] FULL   = HW'(DEG_FULL << HEADING_FRAC_BITS);
  localparam logic signed [TW-1:0] FULL_T = TW'(DEG_FULL << HEADING_FRAC_BITS);
  localparam logic signed [15:0] GOAL_HALF = 16'(DEG_HALF);
  localparam logic signed [TURN_GOAL_W-1:0] GOAL_FULL = TURN_GOAL_W'(DEG_FULL);

  seq_flags_t flags;
  seq_ctrl_t  ctrl;

  logic [15:0] thr [4];
  logic [7:0]  spd [4];

  logic [1:0]         cmd_q;
  logic signed [15:0] px_q;
  logic signed [15:0] py_q;
  logic [12:0]        hd_q;
  logic signed [15:0] tg_q;

  logic                          move_active;
  logic                          turn_active;
  logic                          going_forward;
  logic [15:0]                   move_length;
  logic signed [15:0]            start_x;
  logic signed [15:0]            start_y;
  logic signed [HW-1:0]          start_heading;
  logic signed [TURN_GOAL_W-1:0] turn_goal;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [SQ_W-1:0]          prod;
  logic [RAD_W-1:0]         rad;
  logic [RAD_W:0]           root;
  logic [ITER_W-1:0]        iter;
  logic signed [MREM_W-1:0] mrem;
  logic signed [HW-1:0]     err;
  logic [CORR_W-1:0]        corr;
  logic                     m_met;
  logic [7:0]               m_speed;
  logic signed [TW-1:0]     trem;
  logic                     t_met;
  logic                     t_neg;
  logic [7:0]               t_speed;

  logic in_fire;
  logic out_free;
  logic emit;

  logic signed [DIFF_W-1:0]      px_w, py_w, sx_w, sy_w;
  logic signed [HW-1:0]          hd_w;
  logic                          hd_wrap;
  logic signed [TURN_GOAL_W-1:0] tg_w;
  logic signed [TW-1:0]          goal_t;
  logic signed [TW-1:0]          hd_t;
  logic signed [2*DIFF_W-1:0]    prod_full;
  logic signed [DIFF_W-1:0]      mul_a;
  logic [RAD_W:0]                bit_v;
  logic [RAD_W:0]                try_v;
  logic signed [HW-1:0]          err_raw;
  logic [HW-1:0]                 aerr;
  logic [CORR_W-1:0]             corr_calc;
  logic                          m_hit;
  logic [7:0]                    m_spd;
  logic                          t_hit;
  logic                          t_dn;
  logic [7:0]                    t_spd;
  logic signed [TW-1:0]          thr_s;

  logic       left_ccw_next;
  logic [7:0] left_duty_next;
  logic       right_cw_next;
  logic [7:0] right_duty_next;
  logic       from_turn_next;
  logic       finished_next;
  logic       last_of_tick_next;
  logic [MAG_W-1:0] mag_l;
  logic [MAG_W-1:0] mag_r;

  assign in_stall  = rst || !ctrl.idle;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = !rst;

  assign flags.in_fire   = in_fire;
  assign flags.out_free  = out_free;
  assign flags.is_tick   = (cmd_q == CMD_TICK);
  assign flags.move_on   = move_active;
  assign flags.turn_on   = turn_active;
  assign flags.iter_zero = (iter == '0);

  ddmtc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign px_w    = DIFF_W'(px_q);
  assign py_w    = DIFF_W'(py_q);
  assign sx_w    = DIFF_W'(start_x);
  assign sy_w    = DIFF_W'(start_y);
  assign hd_w    = HW'(hd_q);
  assign hd_wrap = (hd_w > HALF);
  assign tg_w    = TURN_GOAL_W'(tg_q);
  assign goal_t  = TW'(turn_goal);
  assign hd_t    = TW'(hd_q);

  assign mul_a     = (ctrl.op == OP_SQX) ? dx : dy;
  assign prod_full = mul_a * mul_a;

  assign bit_v = (RAD_W + 1)'(1) << {iter, 1'b0};
  assign try_v = root + bit_v;

  assign err_raw   = hd_w - start_heading;
  assign aerr      = err[HW-1] ? HW'(-err) : HW'(err);
  assign corr_calc = (CORR_W'(aerr) * CORR_W'(CORR_GAIN)) >> HEADING_FRAC_BITS;

  always_comb begin
    m_hit = 1'b0;
    m_spd = '0;
    for (int i = NUM_STEPS - 1; i >= 0; i--) begin
      if (mrem >= $signed({3'b000, thr[i]})) begin
        m_hit = 1'b1;
        m_spd = spd[i];
      end
    end
  end

  always_comb begin
    t_hit = 1'b0;
    t_dn  = 1'b0;
    t_spd = '0;
    thr_s = '0;
    for (int i = NUM_STEPS - 1; i >= 0; i--) begin
      thr_s = TW'(thr[i]) << HEADING_FRAC_BITS;
      if (trem >= thr_s) begin
        t_hit = 1'b1;
        t_dn  = 1'b0;
        t_spd = spd[i];
      end else if (trem <= -thr_s) begin
        t_hit = 1'b1;
        t_dn  = 1'b1;
        t_spd = spd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr[0] <= 16'd500;
      thr[1] <= 16'd200;
      thr[2] <= 16'd50;
      thr[3] <= 16'd5;
      spd[0] <= 8'd200;
      spd[1] <= 8'd120;
      spd[2] <= 8'd60;
      spd[3] <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD_0: thr[0] <= cfg_data;
        REG_THRESHOLD_1: thr[1] <= cfg_data;
        REG_THRESHOLD_2: thr[2] <= cfg_data;
        REG_THRESHOLD_3: thr[3] <= cfg_data;
        REG_SPEED_0:     spd[0] <= cfg_data[7:0];
        REG_SPEED_1:     spd[1] <= cfg_data[7:0];
        REG_SPEED_2:     spd[2] <= cfg_data[7:0];
        REG_SPEED_3:     spd[3] <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      case (ctrl.op)
        OP_LATCH: begin
          cmd_q <= command;
          px_q  <= position_x;
          py_q  <= position_y;
          hd_q  <= heading;
          tg_q  <= target;
        end
        OP_START: begin
          if (cmd_q == CMD_MOVE) begin
            move_length   <= tg_q[15] ? 16'(-tg_q) : 16'(tg_q);
            start_x       <= px_q;
            start_y       <= py_q;
            start_heading <= hd_wrap ? hd_w - FULL : hd_w;
          end
          if (cmd_q == CMD_TURN) begin
            turn_goal <= (tg_q > GOAL_HALF) ? tg_w - GOAL_FULL : tg_w;
          end
        end
        OP_DIFF: begin
          dx <= px_w - sx_w;
          dy <= py_w - sy_w;
        end
        OP_SQX: begin
          prod <= prod_full[SQ_W-1:0];
        end
        OP_SQY: begin
          rad  <= RAD_W'(prod);
          prod <= prod_full[SQ_W-1:0];
        end
        OP_SUM: begin
          rad  <= rad + RAD_W'(prod);
          root <= '0;
          iter <= ITER_TOP;
        end
        OP_ROOT: begin
          if ({1'b0, rad} >= try_v) begin
            rad  <= RAD_W'({1'b0, rad} - try_v);
            root <= (root >> 1) + bit_v;
          end else begin
            root <= root >> 1;
          end
          iter <= iter - 1'b1;
        end
        OP_MEVAL: begin
          mrem <= $signed({3'b000, move_length}) - $signed({2'b00, root[ROOT_W-1:0]});
          err  <= hd_wrap ? err_raw - FULL : err_raw;
        end
        OP_MSEL: begin
          corr    <= corr_calc;
          m_met   <= m_hit;
          m_speed <= m_spd;
        end
        OP_TEVAL: begin
          trem <= (goal_t <<< HEADING_FRAC_BITS) - hd_t + (hd_wrap ? FULL_T : '0);
        end
        OP_TSEL: begin
          t_met   <= t_hit;
          t_neg   <= t_dn;
          t_speed <= t_spd;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_active   <= 1'b0;
      turn_active   <= 1'b0;
      going_forward <= 1'b0;
    end else if (ctrl.exec) begin
      case (ctrl.op)
        OP_START: begin
          if (cmd_q == CMD_MOVE) begin
            move_active   <= 1'b1;
            going_forward <= !tg_q[15];
          end
          if (cmd_q == CMD_TURN) begin
            turn_active <= 1'b1;
          end
        end
        OP_MEMIT: begin
          if (!m_met) begin
            move_active <= 1'b0;
          end
        end
        OP_TEMIT: begin
          if (!t_met) begin
            turn_active <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign emit = ctrl.exec && (ctrl.op == OP_MEMIT || ctrl.op == OP_TEMIT);

  always_comb begin
    left_ccw_next     = 1'b0;
    left_duty_next    = '0;
    right_cw_next     = 1'b0;
    right_duty_next   = '0;
    from_turn_next    = (ctrl.op == OP_TEMIT);
    finished_next     = 1'b0;
    last_of_tick_next = 1'b1;
    mag_l             = MAG_W'(m_speed);
    mag_r             = MAG_W'(m_speed);
    if (ctrl.op == OP_MEMIT) begin
      last_of_tick_next = !turn_active;
      if (err < 0) begin
        mag_l = MAG_W'(m_speed) + MAG_W'(corr);
      end
      if (err > 0) begin
        mag_r = MAG_W'(m_speed) + MAG_W'(corr);
      end
      if (m_met) begin
        left_duty_next  = (mag_l > MAG_W'(DUTY_MAX)) ? DUTY_MAX : mag_l[7:0];
        right_duty_next = (mag_r > MAG_W'(DUTY_MAX)) ? DUTY_MAX : mag_r[7:0];
        left_ccw_next   = going_forward && (mag_l != '0);
        right_cw_next   = !going_forward && (mag_r != '0);
      end else begin
        finished_next = 1'b1;
      end
    end else begin
      if (t_met) begin
        left_duty_next  = t_speed;
        right_duty_next = t_speed;
        left_ccw_next   = !t_neg && (t_speed != '0);
        right_cw_next   = !t_neg && (t_speed != '0);
      end else begin
        finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      left_ccw     <= left_ccw_next;
      left_duty    <= left_duty_next;
      right_cw     <= right_cw_next;
      right_duty   <= right_duty_next;
      from_turn    <= from_turn_next;
      finished     <= finished_next;
      last_of_tick <= last_of_tick_next;
    end
  end

`ifndef ASSERT_OFF
  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |->
      (left_duty == 8'd0 && right_duty == 8'd0 && !left_ccw && !right_cw))
    else $error("Finished transaction carries nonzero drive.");

  a_turn_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && from_turn) |-> last_of_tick)
    else $error("Turn transaction not marked last of its tick.");

  a_dir_needs_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!left_ccw || left_duty != 8'd0) && (!right_cw || right_duty != 8'd0)))
    else $error("Direction bit set with zero duty.");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("Output became valid without an emit step.");
`endif

endmodule
